>>> rtl/twg_pkg.sv
// Shared widths, register codes, arithmetic constants and table helpers
// for the table waveform generator. No dependencies.
package twg_pkg;

    // Default number of points in one period
    localparam int TABLE_POINTS_DEF = 50;

    // Field widths
    localparam int SHAPE_W  = 2;
    localparam int AMP_W    = 16;
    localparam int MEAN_W   = 16;
    localparam int PERIOD_W = 24;
    localparam int DAC_W    = 16;
    localparam int PHASE_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int WAVE_W = 16;   // signed table value, |w| <= 6553
    localparam int PROD_W = 33;   // table value times amplitude
    localparam int NUM_W  = 37;   // scaled sample numerator, signed
    localparam int REM_W  = 35;   // numerator once known to be in range

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_CODE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SAMPLE = 2'd3;

    // Shape codes
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd3;
    localparam int SHAPE_COUNT = 4;

    // Register reset values
    localparam logic [SHAPE_W-1:0]  RST_WAVE_SHAPE = SHAPE_SINE;
    localparam logic [AMP_W-1:0]    RST_AMPLITUDE  = 16'd13107;
    localparam logic [MEAN_W-1:0]   RST_MEAN       = 16'd32768;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 24'd1000;

    // Sample scaling: everything is multiplied by 5*65535
    localparam longint DIVISOR = 327675;
    localparam logic signed [NUM_W-1:0] SAMPLE_BIAS = 37'sd6442156035;
    localparam logic signed [NUM_W-1:0] SAT_LIMIT   = 37'sd21474508800; // 65536*DIVISOR

    // Divide by 5*65535: fold by 65535 = 2^16 - 1, then multiply by a reciprocal of 5
    localparam int FOLD_SHIFT = 16;
    localparam int FOLD_A_W   = REM_W - FOLD_SHIFT;   // numerator / 65536
    localparam int FOLD_C_W   = FOLD_A_W + 1;         // that plus the low 16 bits
    localparam logic [FOLD_SHIFT:0] FOLD_MOD = 17'd65535;
    localparam int QUO_T_W    = 20;                   // numerator / 65535
    localparam int QUO5_W     = 21;
    localparam int QUO5_SHIFT = 23;
    localparam logic [QUO5_W-1:0] QUO5_MULT = 21'd1677722;  // ceil(2^23 / 5)
    localparam int DIV_STAGES = 3;

    // Pipeline: sequencer, table read, multiply, sum, fold, fold
    // correction, divide by five into the output word
    localparam int PIPE_STAGES = 4 + DIV_STAGES;

    // Fixed point constants for the table contents (Q30)
    localparam longint QONE     = 64'sd1073741824;
    localparam longint PI_Q     = 64'sd3373259426;
    localparam longint PI3142_Q = 64'sd3373696811;
    localparam longint FULL_K   = 64'sd32767;
    localparam longint TAYLOR_DIV [10] = '{
        64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
        64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420
    };

    typedef logic signed [WAVE_W-1:0] t_wave;

    // Sine table value for an angle in Q30; used at elaboration only
    function automatic longint sine_value(input longint theta);
        longint x;
        longint s;
        longint t;
        int     k;
        if (theta > 3 * PI_Q / 2) begin
            x = theta - 2 * PI_Q;
        end else if (theta > PI_Q / 2) begin
            x = PI_Q - theta;
        end else begin
            x = theta;
        end
        s = x;
        t = x;
        for (k = 0; k < 10; k++) begin
            t = t * x / QONE;
            t = t * x / QONE;
            t = -t / TAYLOR_DIV[k];
            s = s + t;
        end
        return s * FULL_K / (5 * QONE);
    endfunction

endpackage

>>> rtl/twg_seq.sv
// Tick counter and phase position of the table waveform generator.
// Depends on twg_pkg.
module twg_seq
    import twg_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_restart,
    input  logic                            i_load,
    input  logic [PERIOD_W-1:0]             i_period,
    output logic                            o_emit,
    output logic [$clog2(TABLE_POINTS)-1:0] o_pos
);

    localparam int PW = $clog2(TABLE_POINTS);

    logic [PERIOD_W-1:0] r_tick;
    logic [PW-1:0]       r_phase;
    logic [PW-1:0]       r_pos;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W:0]   n_tick;
    logic                w_wrap;
    logic [PW:0]         w_phase_inc;
    logic [PW-1:0]       n_phase;

    // Treat a zero period as one tick
    assign w_period = (i_period == '0) ? PERIOD_W'(1) : i_period;
    assign n_tick   = {1'b0, r_tick} + (PERIOD_W+1)'(1);
    assign w_wrap   = (n_tick >= {1'b0, w_period});
    assign o_emit   = i_accept && !i_restart && w_wrap;

    // Wrap the phase after the last point
    assign w_phase_inc = {1'b0, r_phase} + (PW+1)'(1);
    assign n_phase     = (w_phase_inc >= (PW+1)'(TABLE_POINTS)) ? '0 : w_phase_inc[PW-1:0];

    // Count accepted words; advance the phase when the count wraps, clear both on restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            if (i_restart) begin
                r_tick  <= '0;
                r_phase <= '0;
            end else if (!w_wrap) begin
                r_tick  <= n_tick[PERIOD_W-1:0];
            end else begin
                r_tick  <= '0;
                r_phase <= n_phase;
            end
        end
    end

    // Hold the sampled position for the table read
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos <= r_phase;
        end
    end

    assign o_pos = r_pos;

endmodule

>>> rtl/twg_wave_rom.sv
// Waveform table memory: four shapes of one period, with a registered
// read. Contents are built at elaboration. Depends on twg_pkg.
module twg_wave_rom
    import twg_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [SHAPE_W-1:0]              i_shape,
    input  logic [$clog2(TABLE_POINTS)-1:0] i_pos,
    output t_wave                           o_word,
    output logic [$clog2(TABLE_POINTS)-1:0] o_pos
);

    localparam int PW = $clog2(TABLE_POINTS);

    t_wave         w_tab [SHAPE_COUNT][TABLE_POINTS];
    t_wave         r_word;
    logic [PW-1:0] r_pos;

    // Build one period of each shape
    for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_tab
        localparam longint I = g;
        localparam longint N = TABLE_POINTS;
        localparam longint THETA = I * 2 * PI3142_Q / N;
        localparam longint W_SIN = sine_value(THETA);
        localparam longint W_SQR = (I <= N / 2) ? FULL_K / 5 : -(FULL_K / 5);
        localparam longint W_SAW = (I <= N / 2) ? (2 * I) * FULL_K / (5 * N)
                                                : (2 * I - 2 * N) * FULL_K / (5 * N);
        localparam longint W_TRI = (I <= N / 4)     ? (4 * I) * FULL_K / (5 * N) :
                                   (I <= N * 3 / 4) ? (2 * N - 4 * I) * FULL_K / (5 * N)
                                                    : (4 * I - 4 * N) * FULL_K / (5 * N);
        assign w_tab[SHAPE_SINE][g]     = WAVE_W'(W_SIN);
        assign w_tab[SHAPE_SQUARE][g]   = WAVE_W'(W_SQR);
        assign w_tab[SHAPE_SAWTOOTH][g] = WAVE_W'(W_SAW);
        assign w_tab[SHAPE_TRIANGLE][g] = WAVE_W'(W_TRI);
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= w_tab[i_shape][i_pos];
            r_pos  <= i_pos;
        end
    end

    assign o_word = r_word;
    assign o_pos  = r_pos;

endmodule

>>> rtl/twg_scale.sv
// Amplitude multiply and offset sum: two pipeline stages that turn a table
// value into the scaled sample numerator. Depends on twg_pkg.
module twg_scale
    import twg_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic [1:0]                      i_load,
    input  t_wave                           i_word,
    input  logic [$clog2(TABLE_POINTS)-1:0] i_pos,
    input  logic [AMP_W-1:0]                i_amp,
    input  logic [MEAN_W-1:0]               i_mean,
    output logic signed [NUM_W-1:0]         o_num,
    output logic [$clog2(TABLE_POINTS)-1:0] o_pos
);

    localparam int PW = $clog2(TABLE_POINTS);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [PW-1:0]            r_pos_a;
    logic signed [NUM_W-1:0]  w_prod_ext;
    logic signed [NUM_W-1:0]  w_mean_ext;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [NUM_W-1:0]  r_num;
    logic [PW-1:0]            r_pos_b;

    // Multiply table value by amplitude
    assign w_prod = i_word * $signed({1'b0, i_amp});

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_prod  <= w_prod;
            r_pos_a <= i_pos;
        end
    end

    // Form 15*prod + bias + 131070*mean with shifts
    assign w_prod_ext = {{(NUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_mean_ext = $signed({{(NUM_W-MEAN_W){1'b0}}, i_mean});
    assign w_num = (w_prod_ext <<< 4) - w_prod_ext + SAMPLE_BIAS
                 + (w_mean_ext <<< 17) - (w_mean_ext <<< 1);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_num   <= w_num;
            r_pos_b <= r_pos_a;
        end
    end

    assign o_num = r_num;
    assign o_pos = r_pos_b;

endmodule

>>> rtl/twg_div.sv
// Saturation check and divide by 5*65535: a fold by 65535, its correction,
// then a reciprocal multiply by one fifth into the output register. Depends on twg_pkg.
module twg_div
    import twg_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic [DIV_STAGES-1:0]           i_load,
    input  logic signed [NUM_W-1:0]         i_num,
    input  logic [$clog2(TABLE_POINTS)-1:0] i_pos,
    output logic [DAC_W-1:0]                o_dac,
    output logic [$clog2(TABLE_POINTS)-1:0] o_pos
);

    localparam int PW = $clog2(TABLE_POINTS);

    typedef struct packed {
        logic [FOLD_A_W-1:0] hi;
        logic [FOLD_C_W-1:0] sum;
        logic                sat_lo;
        logic                sat_hi;
        logic [PW-1:0]       pos;
    } t_fold_word;

    typedef struct packed {
        logic [QUO_T_W-1:0] quo;
        logic               sat_lo;
        logic               sat_hi;
        logic [PW-1:0]      pos;
    } t_quo_word;

    t_fold_word                    n_fold;
    t_fold_word                    r_fold;
    t_quo_word                     n_quo;
    t_quo_word                     r_quo;
    logic [REM_W-1:0]              w_rem;
    logic [FOLD_C_W-FOLD_SHIFT-1:0] w_carry;
    logic [FOLD_SHIFT:0]           w_resid;
    logic [QUO_T_W+QUO5_W-1:0]     w_prod;
    logic [DAC_W-1:0]              w_quo5;
    logic [DAC_W-1:0]              r_dac;
    logic [PW-1:0]                 r_pos;

    // Classify and fold: x = hi*65535 + (hi + lo)
    assign w_rem = i_num[REM_W-1:0];

    always_comb begin
        n_fold.hi     = w_rem[REM_W-1:FOLD_SHIFT];
        n_fold.sum    = FOLD_C_W'(w_rem[REM_W-1:FOLD_SHIFT])
                      + FOLD_C_W'(w_rem[FOLD_SHIFT-1:0]);
        n_fold.sat_lo = i_num[NUM_W-1];
        n_fold.sat_hi = !i_num[NUM_W-1] && (i_num >= SAT_LIMIT);
        n_fold.pos    = i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_fold <= n_fold;
        end
    end

    // Fold the sum once more and correct the last unit
    assign w_carry = r_fold.sum[FOLD_C_W-1:FOLD_SHIFT];
    assign w_resid = {1'b0, r_fold.sum[FOLD_SHIFT-1:0]} + (FOLD_SHIFT+1)'(w_carry);

    always_comb begin
        n_quo.quo    = QUO_T_W'(r_fold.hi) + QUO_T_W'(w_carry)
                     + QUO_T_W'(w_resid >= FOLD_MOD);
        n_quo.sat_lo = r_fold.sat_lo;
        n_quo.sat_hi = r_fold.sat_hi;
        n_quo.pos    = r_fold.pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_quo <= n_quo;
        end
    end

    // Divide by five with a reciprocal multiply
    assign w_prod = r_quo.quo * QUO5_MULT;
    assign w_quo5 = w_prod[QUO5_SHIFT+DAC_W-1:QUO5_SHIFT];

    // Clamp and hold the output word
    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            if (r_quo.sat_lo) begin
                r_dac <= '0;
            end else if (r_quo.sat_hi) begin
                r_dac <= '1;
            end else begin
                r_dac <= w_quo5;
            end
            r_pos <= r_quo.pos;
        end
    end

    assign o_dac = r_dac;
    assign o_pos = r_pos;

endmodule

>>> rtl/table_waveform_generator.sv
// Table waveform generator top level: configuration registers, pipeline
// valid chain and stall logic. Depends on twg_pkg, twg_seq, twg_wave_rom,
// twg_scale and twg_div.
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  tick in  i_valid, o_stall, i_restart               in
//  sample   o_valid, i_stall, o_dac_code, o_phase_index  out
//  config   i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in
//
// One tick word is taken every cycle while o_stall is low; the sample that
// a tick produces passes through the seven stages: sequencer, table
// read, multiply, offset sum, fold, fold correction and divide by five.
// Reset is synchronous and clears tick count, phase and the valid chain.
// Each stage holds its word only while the stage after it is full and
// holding, so o_stall rises only when every stage back to the front is full.
// The configuration port is always ready.
module table_waveform_generator
    import twg_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DAC_W-1:0]      o_dac_code,
    output logic [PHASE_W-1:0]    o_phase_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(TABLE_POINTS);

    logic [SHAPE_W-1:0]     r_wave_shape;
    logic [AMP_W-1:0]       r_amplitude_code;
    logic [MEAN_W-1:0]      r_mean_code;
    logic [PERIOD_W-1:0]    r_ticks_per_sample;
    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] w_free;
    logic                   w_accept;
    logic                   w_emit;
    logic [PW-1:0]          w_s0_pos;
    t_wave                  w_s1_word;
    logic [PW-1:0]          w_s1_pos;
    logic signed [NUM_W-1:0] w_s3_num;
    logic [PW-1:0]          w_s3_pos;
    logic [DAC_W-1:0]       w_dac;
    logic [PW-1:0]          w_out_pos;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape       <= RST_WAVE_SHAPE;
            r_amplitude_code   <= RST_AMPLITUDE;
            r_mean_code        <= RST_MEAN;
            r_ticks_per_sample <= RST_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WAVE_SHAPE:       r_wave_shape       <= i_cfg_data[SHAPE_W-1:0];
                REG_AMPLITUDE_CODE:   r_amplitude_code   <= i_cfg_data[AMP_W-1:0];
                REG_MEAN_CODE:        r_mean_code        <= i_cfg_data[MEAN_W-1:0];
                REG_TICKS_PER_SAMPLE: r_ticks_per_sample <= i_cfg_data[PERIOD_W-1:0];
            endcase
        end
    end

    // A stage can load when it is empty or its word moves on
    always_comb begin
        w_free[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || !i_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_free[k] = !r_valid[k] || w_free[k+1];
        end
    end

    assign o_stall  = !w_free[0];
    assign w_accept = i_valid && !o_stall;

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_free[0]) begin
                r_valid[0] <= w_emit;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (w_free[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    twg_seq #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_restart(i_restart),
        .i_load   (w_free[0]),
        .i_period (r_ticks_per_sample),
        .o_emit   (w_emit),
        .o_pos    (w_s0_pos)
    );

    twg_wave_rom #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_load (w_free[1]),
        .i_shape(r_wave_shape),
        .i_pos  (w_s0_pos),
        .o_word (w_s1_word),
        .o_pos  (w_s1_pos)
    );

    twg_scale #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_scale (
        .i_clk (i_clk),
        .i_load(w_free[3:2]),
        .i_word(w_s1_word),
        .i_pos (w_s1_pos),
        .i_amp (r_amplitude_code),
        .i_mean(r_mean_code),
        .o_num (w_s3_num),
        .o_pos (w_s3_pos)
    );

    twg_div #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_div (
        .i_clk (i_clk),
        .i_load(w_free[PIPE_STAGES-1:4]),
        .i_num (w_s3_num),
        .i_pos (w_s3_pos),
        .o_dac (w_dac),
        .o_pos (w_out_pos)
    );

    assign o_valid       = r_valid[PIPE_STAGES-1];
    assign o_dac_code    = w_dac;
    assign o_phase_index = PHASE_W'(w_out_pos);

`ifndef ASSERT_OFF
    // A restart tick never starts a sample
    a_restart_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart) |=> !r_valid[0])
        else $error("restart tick started a sample");

    // With a period of one tick, every plain tick starts a sample
    a_fast_period_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_restart && (r_ticks_per_sample <= PERIOD_W'(1))) |=> r_valid[0])
        else $error("sample missing at period of one tick");

    // Sampled position stays inside the table
    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] |-> ({1'b0, w_s0_pos} < (PW+1)'(TABLE_POINTS)))
        else $error("phase position beyond table");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking bench for table_waveform_generator: a directed table, then random
// register settings with tick bursts, checked against an in-bench sample predictor.
// Depends on twg_pkg and the table_waveform_generator RTL.
module tb_top;
    import twg_pkg::*;

    localparam int RANDOM_TICKS       = 460;
    localparam int DRAIN_CYCLES       = 2 * PIPE_STAGES + 4;
    localparam longint POINTS         = TABLE_POINTS_DEF;

    typedef struct packed {
        logic [DAC_W-1:0]   dac;
        logic [PHASE_W-1:0] phase;
    } t_sample;

    typedef enum logic {ROW_WRITE, ROW_TICKS} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   restart;
        int unsigned            count;
        bit                     typed;
        logic [DAC_W-1:0]       dac;
        logic [PHASE_W-1:0]     phase;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_restart;
    logic                  o_valid;
    logic                  i_stall;
    logic [DAC_W-1:0]      o_dac_code;
    logic [PHASE_W-1:0]    o_phase_index;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copy of the registers and sequencer state
    logic [SHAPE_W-1:0]  cur_shape;
    logic [AMP_W-1:0]    cur_amp;
    logic [MEAN_W-1:0]   cur_mean;
    logic [PERIOD_W-1:0] cur_period;
    logic [PERIOD_W-1:0] tick_cnt;
    logic [PHASE_W-1:0]  table_pos;

    t_sample   pending_samples[$];
    t_plan_row plan[$];
    int        error_count    = 0;
    int        send_idle_pct  = 21;
    int        stall_pct      = 78;

    table_waveform_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dac_code    (o_dac_code),
        .o_phase_index (o_phase_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case a word never arrives
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Sine in Q30, Taylor series after folding the angle into +-pi/2
    function automatic longint sine_q30(input longint ang);
        longint x;
        longint acc;
        longint term;
        int     k;
        if (ang > 3 * PI_Q / 2) begin
            x = ang - 2 * PI_Q;
        end else if (ang > PI_Q / 2) begin
            x = PI_Q - ang;
        end else begin
            x = ang;
        end
        acc  = x;
        term = x;
        for (k = 1; k <= 10; k++) begin
            term = term * x / QONE;
            term = term * x / QONE;
            term = -term / longint'((2 * k) * (2 * k + 1));
            acc  = acc + term;
        end
        return acc;
    endfunction

    // Signed table level for one position of the selected shape
    function automatic longint level_at(input logic [SHAPE_W-1:0] shape, input longint pos);
        case (shape)
            SHAPE_SINE: begin
                return sine_q30(pos * 2 * PI3142_Q / POINTS) * FULL_K / (5 * QONE);
            end
            SHAPE_SQUARE: begin
                return (pos <= POINTS / 2) ? FULL_K / 5 : -(FULL_K / 5);
            end
            SHAPE_SAWTOOTH: begin
                if (pos <= POINTS / 2) return (2 * pos) * FULL_K / (5 * POINTS);
                return (2 * pos - 2 * POINTS) * FULL_K / (5 * POINTS);
            end
            default: begin
                if (pos <= POINTS / 4) return (4 * pos) * FULL_K / (5 * POINTS);
                if (pos <= POINTS * 3 / 4) return (2 * POINTS - 4 * pos) * FULL_K / (5 * POINTS);
                return (4 * pos - 4 * POINTS) * FULL_K / (5 * POINTS);
            end
        endcase
    endfunction

    // Scale level by amplitude, add offset and mean, clamp to the DAC range
    function automatic logic [DAC_W-1:0] dac_from_level(input longint lvl);
        longint num;
        longint q;
        num = 15 * lvl * longint'(cur_amp) + 64'sd6442156035 + 131070 * longint'(cur_mean);
        if (num < 0) return '0;
        q = num / DIVISOR;
        if (q > 65535) q = 65535;
        return q[DAC_W-1:0];
    endfunction

    // Advance the sequencer by one tick; returns 1 when a sample is due
    function automatic bit predict_tick(input logic restart, output t_sample s);
        int unsigned eff_period;
        int unsigned pos;
        s = '0;
        eff_period = (cur_period == '0) ? 1 : int'(cur_period);
        if (restart) begin
            table_pos = '0;
            tick_cnt  = '0;
            return 1'b0;
        end
        if (int'(tick_cnt) + 1 < eff_period) begin
            tick_cnt = tick_cnt + 1'b1;
            return 1'b0;
        end
        tick_cnt = '0;
        pos      = int'(table_pos) % int'(POINTS);
        s.dac    = dac_from_level(level_at(cur_shape, longint'(pos)));
        s.phase  = pos[PHASE_W-1:0];
        table_pos = (pos + 1 >= POINTS) ? '0 : PHASE_W'(pos + 1);
        return 1'b1;
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WAVE_SHAPE:       cur_shape  = data[SHAPE_W-1:0];
            REG_AMPLITUDE_CODE:   cur_amp    = data[AMP_W-1:0];
            REG_MEAN_CODE:        cur_mean   = data[MEAN_W-1:0];
            REG_TICKS_PER_SAMPLE: cur_period = data[PERIOD_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one tick word, with random idle cycles ahead of it
    task automatic send_tick(input logic restart, input bit typed,
                             input logic [DAC_W-1:0] t_dac, input logic [PHASE_W-1:0] t_phase);
        t_sample s;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        if (predict_tick(restart, s)) begin
            if (typed) begin
                s.dac   = t_dac;
                s.phase = t_phase;
            end
            pending_samples.push_back(s);
        end
    endtask

    // Hold off until every expected word is back and the pipeline is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_sample();
        t_sample want;
        if (pending_samples.size() == 0) begin
            flag_error($sformatf("unexpected sample dac=%0d phase=%0d",
                                 o_dac_code, o_phase_index));
        end else begin
            want = pending_samples.pop_front();
            if (o_dac_code !== want.dac)
                flag_error($sformatf("dac_code %0d, expected %0d (phase %0d)",
                                     o_dac_code, want.dac, want.phase));
            if (o_phase_index !== want.phase)
                flag_error($sformatf("phase_index %0d, expected %0d",
                                     o_phase_index, want.phase));
        end
    endtask

    // Take sample words and drive a random stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_sample();
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        return '{ROW_WRITE, idx, data, 1'b0, 0, 1'b0, '0, '0};
    endfunction

    function automatic t_plan_row tick_row(input int unsigned n, input logic restart,
                                           input bit typed, input logic [DAC_W-1:0] dac,
                                           input logic [PHASE_W-1:0] phase);
        return '{ROW_TICKS, '0, '0, restart, n, typed, dac, phase};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return CFG_DATA_W'($urandom);
        if (r < 12) return '0;
        if (r < 14) return '1;
        if (r < 32) return CFG_DATA_W'($urandom_range(5, 40));
        return CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    initial begin
        t_plan_row   row;
        int unsigned j;
        int          random_ticks;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;

        cur_shape  = RST_WAVE_SHAPE;
        cur_amp    = RST_AMPLITUDE;
        cur_mean   = RST_MEAN;
        cur_period = RST_PERIOD;
        tick_cnt   = '0;
        table_pos  = '0;

        // Directed table: reset values, extremes, each shape, the corner cases
        plan.push_back(tick_row(10, 1'b0, 1'b0, '0, '0));             // reset period counts on
        plan.push_back(cfg_row(REG_TICKS_PER_SAMPLE, 24'd1));         // period below count
        plan.push_back(tick_row(1, 1'b0, 1'b1, 16'd32767, 6'd0));     // reset settings
        plan.push_back(tick_row(49, 1'b0, 1'b0, '0, '0));             // rest of sine, wrap
        plan.push_back(cfg_row(REG_WAVE_SHAPE, {22'h3FFFFF, SHAPE_SQUARE}));
        plan.push_back(cfg_row(REG_AMPLITUDE_CODE, 24'hFFFFFF));
        plan.push_back(cfg_row(REG_MEAN_CODE, 24'hFFFFFF));
        plan.push_back(tick_row(1, 1'b0, 1'b1, 16'd65533, 6'd0));     // top extreme
        plan.push_back(cfg_row(REG_MEAN_CODE, 24'd0));
        plan.push_back(tick_row(1, 1'b1, 1'b0, '0, '0));              // restart
        plan.push_back(tick_row(27, 1'b0, 1'b1, 16'd1, 6'd26));       // bottom extreme
        plan.push_back(cfg_row(REG_AMPLITUDE_CODE, 24'd0));
        plan.push_back(tick_row(1, 1'b0, 1'b1, 16'd19660, 6'd27));    // offset alone
        plan.push_back(cfg_row(REG_AMPLITUDE_CODE, 24'd40000));
        plan.push_back(cfg_row(REG_MEAN_CODE, 24'd20000));
        plan.push_back(cfg_row(REG_WAVE_SHAPE, {22'd0, SHAPE_SAWTOOTH}));
        plan.push_back(tick_row(50, 1'b0, 1'b0, '0, '0));
        plan.push_back(cfg_row(REG_WAVE_SHAPE, {22'd0, SHAPE_TRIANGLE}));
        plan.push_back(tick_row(50, 1'b0, 1'b0, '0, '0));
        plan.push_back(cfg_row(REG_TICKS_PER_SAMPLE, 24'd0));         // zero period
        plan.push_back(tick_row(3, 1'b0, 1'b0, '0, '0));
        plan.push_back(cfg_row(REG_TICKS_PER_SAMPLE, 24'hFFFFFF));
        plan.push_back(tick_row(40, 1'b0, 1'b0, '0, '0));
        plan.push_back(cfg_row(REG_TICKS_PER_SAMPLE, 24'd5));         // period below count
        plan.push_back(tick_row(3, 1'b0, 1'b0, '0, '0));
        plan.push_back(tick_row(1, 1'b1, 1'b0, '0, '0));              // restart mid-count
        plan.push_back(tick_row(7, 1'b0, 1'b0, '0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_WRITE) begin
                wait_drained();
                write_register(row.idx, row.data);
            end else begin
                for (j = 0; j < row.count; j++) begin
                    send_tick(row.restart, row.typed && (j == row.count - 1),
                              row.dac, row.phase);
                end
            end
        end

        // Random bursts under fresh settings; idle profile moves on with progress
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            if (random_ticks < RANDOM_TICKS / 3) begin
                send_idle_pct = 21;
                stall_pct     = 78;
            end else if (random_ticks < 2 * RANDOM_TICKS / 3) begin
                send_idle_pct = 78;
                stall_pct     = 21;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            wait_drained();
            write_register(REG_WAVE_SHAPE, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 3) != 0) write_register(REG_AMPLITUDE_CODE, pick_level());
            if ($urandom_range(0, 3) != 0) write_register(REG_MEAN_CODE, pick_level());
            write_register(REG_TICKS_PER_SAMPLE, pick_period());
            repeat ($urandom_range(10, 60)) begin
                send_tick($urandom_range(0, 99) < 4, 1'b0, '0, '0);
                random_ticks++;
            end
        end

        wait_drained();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
